@@ rtl/core/swb_pkg.sv @@
// Shared types and constants for the stopwatch bank.
package swb_pkg;

   localparam int unsigned SlotCountDefault = 16;
   localparam logic [31:0] TicksPerMsReset  = 32'd10000;
   localparam logic [30:0] MsMax            = 31'h7FFF_FFFF;

   typedef enum logic [1:0] {
      KIND_ADVANCE = 2'd0,
      KIND_START   = 2'd1,
      KIND_READ    = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_REAL = 2'd0,
      MODE_GAME = 2'd1,
      MODE_IMM  = 2'd2,
      MODE_BAD  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      RD_ERASE   = 2'd0,
      RD_RESTART = 2'd1,
      RD_KEEP    = 2'd2,
      RD_KEEP2   = 2'd3
   } rdopt_type;

   localparam logic [1:0] CSR_REAL   = 2'd0;
   localparam logic [1:0] CSR_GAME   = 2'd1;
   localparam logic [1:0] CSR_PAUSED = 2'd2;

   // Commands from controller to datapath.
   typedef struct packed {
      logic latch;     // capture request fields
      logic tick_add;  // tick_count += delta
      logic div_start; // load divider
      logic div_step;  // one restoring step
      logic [1:0] div_sel; // 0 real, 1 game, 2 immediate read
      logic rem_save;  // store remainder for selected base
      logic walk_step; // credit one slot
      logic walk_clr;  // reset slot pointer
      logic start_do;  // arm slot
      logic read_do;   // read-side update
      logic rsp_load;  // load output register
   } cmd_type;

   typedef struct packed {
      logic walk_last;
      logic div_last;
   } stat_type;

endpackage

@@ rtl/core/swb_datapath.sv @@
// Datapath: tick counter, remainders, serial divider, slot bank.
module swb_datapath #(
   parameter int unsigned SLOT_COUNT = swb_pkg::SlotCountDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  swb_pkg::cmd_type  cmd,
   output swb_pkg::stat_type stat,
   input  logic [31:0]       req_delta_ticks,
   input  logic [3:0]        req_slot,
   input  logic [1:0]        req_option,
   input  logic [31:0]       real_tpm,
   input  logic [31:0]       game_tpm,
   output logic [30:0]       rsp_elapsed_ms,
   output logic              rsp_found
);
   import swb_pkg::*;

   localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic [31:0] delta_ff;
   logic [3:0]  slot_ff;
   logic [1:0]  option_ff;
   logic [63:0] tick_ff;
   logic [31:0] rrem_ff, grem_ff;
   logic [63:0] quo_ff;
   logic [63:0] rem_ff;
   logic [31:0] dvs_ff;
   logic [5:0]  dcnt_ff;
   logic [SW-1:0] ptr_ff;
   logic [SLOT_COUNT-1:0] armed_ff;
   logic [1:0]  mode_ff [SLOT_COUNT];
   logic [63:0] value_ff [SLOT_COUNT];
   logic [30:0] ms_ff;
   logic        found_ff;

   logic [31:0] dv_raw;
   logic [63:0] dividend;
   logic [64:0] trial;
   logic        slot_ok;
   logic [SW-1:0] sidx;
   logic [63:0] sum;
   logic [63:0] rd_ms;

   assign sidx    = SW'({28'd0, slot_ff});
   assign slot_ok = ({28'd0, slot_ff} < 32'(SLOT_COUNT)) && armed_ff[sidx];

   // Divider operand selection
   always_comb begin
      case (cmd.div_sel)
         MODE_REAL: dv_raw = real_tpm;
         MODE_GAME: dv_raw = game_tpm;
         default:   dv_raw = real_tpm;
      endcase
      case (cmd.div_sel)
         MODE_REAL: dividend = {32'd0, delta_ff} + {32'd0, rrem_ff};
         MODE_GAME: dividend = {32'd0, delta_ff} + {32'd0, grem_ff};
         default:   dividend = tick_ff - value_ff[sidx];
      endcase
      // partial remainder stays below the divisor, so bit 64 is the borrow
      trial = {rem_ff, quo_ff[63]} - {33'd0, dvs_ff};
   end

   assign stat.div_last  = (dcnt_ff == 6'd63);
   assign stat.walk_last = (ptr_ff == SW'(SLOT_COUNT - 1));

   // Restoring divider, one bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= (dv_raw == 32'd0) ? 32'd1 : dv_raw;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (!trial[64]) begin
            rem_ff <= trial[63:0];
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[62:0], quo_ff[63]};
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 6'd1;
      end
   end

   assign sum = value_ff[ptr_ff] + quo_ff;

   assign rd_ms = (mode_ff[sidx] == MODE_IMM) ? quo_ff : value_ff[sidx];

   // Control state: counters, remainders, armed bits and slot modes
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         rrem_ff  <= '0;
         grem_ff  <= '0;
         ptr_ff   <= '0;
         armed_ff <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) mode_ff[i] <= MODE_REAL;
      end else begin
         if (cmd.tick_add) tick_ff <= tick_ff + {32'd0, delta_ff};
         if (cmd.rem_save) begin
            if (cmd.div_sel == MODE_REAL) rrem_ff <= rem_ff[31:0];
            else                          grem_ff <= rem_ff[31:0];
         end
         if (cmd.walk_clr)       ptr_ff <= '0;
         else if (cmd.walk_step) ptr_ff <= ptr_ff + SW'(1);
         if (cmd.start_do && ({28'd0, slot_ff} < 32'(SLOT_COUNT))
             && option_ff != MODE_BAD) begin
            armed_ff[sidx] <= 1'b1;
            mode_ff[sidx]  <= option_ff;
         end
         if (cmd.read_do && slot_ok && option_ff == RD_ERASE)
            armed_ff[sidx] <= 1'b0;
      end
   end

   // Slot values, request capture, result register
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         delta_ff  <= req_delta_ticks;
         slot_ff   <= req_slot;
         option_ff <= req_option;
      end
      if (cmd.walk_step && armed_ff[ptr_ff] && mode_ff[ptr_ff] == cmd.div_sel)
         value_ff[ptr_ff] <= (sum < value_ff[ptr_ff]) ? '1 : sum;
      if (cmd.start_do && ({28'd0, slot_ff} < 32'(SLOT_COUNT))
          && option_ff != MODE_BAD)
         value_ff[sidx] <= (option_ff == MODE_IMM) ? tick_ff : '0;
      if (cmd.read_do && slot_ok && option_ff == RD_RESTART)
         value_ff[sidx] <= (mode_ff[sidx] == MODE_IMM) ? tick_ff : '0;
      if (cmd.rsp_load) begin
         found_ff <= slot_ok;
         ms_ff    <= !slot_ok ? '0 : ((rd_ms > {33'd0, MsMax}) ? MsMax : rd_ms[30:0]);
      end
   end

   assign rsp_elapsed_ms = ms_ff;
   assign rsp_found      = found_ff;
endmodule

@@ rtl/core/swb_ctrl.sv @@
// Controller state machine sequencing the datapath.
module swb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_kind,
   input  logic              paused,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output swb_pkg::cmd_type  cmd,
   input  swb_pkg::stat_type stat
);
   import swb_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_DLOAD = 8'b0000_0010,
      ST_DIV   = 8'b0000_0100,
      ST_WALK  = 8'b0000_1000,
      ST_ILOAD = 8'b0001_0000,
      ST_IDIV  = 8'b0010_0000,
      ST_RSP   = 8'b0100_0000,
      ST_START = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      base_ff, base_in;
   logic      rv_ff, rv_in;
   logic      acc;

   // a waiting result only holds back the next read, in ST_RSP
   assign req_stall = (state_ff != ST_IDLE);
   assign acc       = req_valid && !req_stall;
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      base_in  = base_ff;
      rv_in    = rv_ff && rsp_stall;
      cmd      = '0;
      cmd.div_sel = {1'b0, base_ff};
      case (state_ff)
         ST_IDLE: begin
            cmd.latch = acc;
            if (acc) begin
               case (req_kind)
                  KIND_ADVANCE: state_in = ST_DLOAD;
                  KIND_START:   state_in = ST_START;
                  KIND_READ:    state_in = ST_ILOAD;
                  default:      state_in = ST_IDLE;
               endcase
               base_in = 1'b0;
            end
         end
         ST_DLOAD: begin
            // first pass also bumps the tick counter
            cmd.tick_add  = !base_ff;
            cmd.div_start = 1'b1;
            state_in = paused ? ST_IDLE : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            cmd.rem_save  = stat.walk_last;
            cmd.walk_clr  = stat.walk_last;
            if (stat.walk_last) begin
               base_in  = !base_ff;
               state_in = base_ff ? ST_IDLE : ST_DLOAD;
            end
         end
         ST_START: begin
            cmd.start_do = 1'b1;
            state_in = ST_IDLE;
         end
         ST_ILOAD: begin
            cmd.div_sel   = MODE_IMM;
            cmd.div_start = 1'b1;
            state_in = ST_IDIV;
         end
         ST_IDIV: begin
            cmd.div_sel  = MODE_IMM;
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_RSP;
         end
         ST_RSP: begin
            cmd.div_sel = MODE_IMM;
            if (!(rv_ff && rsp_stall)) begin
               cmd.rsp_load = 1'b1;
               cmd.read_do  = 1'b1;
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         rv_ff    <= rv_in;
      end
   end
endmodule

@@ rtl/core/stopwatch_bank_with_ms_prescaler.sv @@
// Stopwatch bank top level: configuration registers, controller, datapath.
//
// Usage: items enter on req_* (valid/stall). kind 0 advances time by
// req_delta_ticks, kind 1 arms a slot, kind 2 reads a slot and returns one
// transaction on rsp_* (elapsed_ms, found). Kind 3 is dropped.
// Each advance runs the one-bit-per-cycle 64-bit divider and then the
// one-slot-per-cycle credit walk, first for the real base and then for the
// game base; when paused it only adds to the tick count. A start arms the
// slot directly. A read runs the divider, whose quotient serves an
// immediate-mode slot, then loads the result register and raises rsp_valid.
// One item is in work at a time; req_stall is high while busy.
// The result register holds a read result while rsp_stall is high; the
// next item is taken meanwhile, but a further read waits for it.
// Reset (synchronous, active high) clears the tick count, remainders and
// armed bits, and loads both divisors with 10000 and paused with 0.
// csr_* writes are always ready and must be issued only while idle.
module stopwatch_bank_with_ms_prescaler #(
   parameter int unsigned SLOT_COUNT = swb_pkg::SlotCountDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_delta_ticks,
   input  logic [3:0]  req_slot,
   input  logic [1:0]  req_option,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_elapsed_ms,
   output logic        rsp_found,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import swb_pkg::*;

   logic [31:0] real_ff, game_ff;
   logic        paused_ff;
   cmd_type     cmd;
   stat_type    stat;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         real_ff   <= TicksPerMsReset;
         game_ff   <= TicksPerMsReset;
         paused_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REAL:   real_ff   <= csr_wdata;
            CSR_GAME:   game_ff   <= csr_wdata;
            CSR_PAUSED: paused_ff <= csr_wdata[0];
            default:    ;
         endcase
      end
   end

   swb_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_kind,
      .paused(paused_ff), .rsp_valid, .rsp_stall, .cmd, .stat
   );

   swb_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
      .clock, .reset, .cmd, .stat, .req_delta_ticks, .req_slot,
      .req_option, .real_tpm(real_ff), .game_tpm(game_ff),
      .rsp_elapsed_ms, .rsp_found
   );
endmodule

@@ dv/tb_stopwatch_bank_with_ms_prescaler.sv @@
// Testbench for the stopwatch bank: directed and random traffic with a result scoreboard.
`timescale 1ns / 100ps

module tb_stopwatch_bank_with_ms_prescaler;
   import swb_pkg::*;

   localparam int NSLOT = 16;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [31:0] req_delta_ticks;
   logic [3:0]  req_slot;
   logic [1:0]  req_option;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [30:0] rsp_elapsed_ms;
   logic        rsp_found;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   stopwatch_bank_with_ms_prescaler dut (.*);

   // Predictor state
   logic [31:0] real_div, game_div;
   logic        is_paused;
   logic [63:0] ticks;
   logic [31:0] real_rem, game_rem;
   logic        armed [NSLOT];
   mode_type    mode [NSLOT];
   logic [63:0] value [NSLOT];

   typedef struct packed {
      logic [30:0] ms;
      logic        found;
   } read_result_type;

   read_result_type pending_reads[$];

   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_req = 0;
   int hold_done = 0;
   int hold_cycles = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Converts ticks to whole ms on one base and updates its carry.
   function automatic logic [63:0] base_ms(input logic [31:0] delta,
                                           inout logic [31:0] rem,
                                           input logic [31:0] div);
      logic [63:0] d, sum;
      d = (div == 0) ? 64'd1 : {32'd0, div};
      sum = {32'd0, delta} + {32'd0, rem};
      rem = 32'(sum % d);
      return sum / d;
   endfunction

   task automatic credit_slots(input mode_type m, input logic [63:0] ms);
      logic [64:0] s;
      for (int i = 0; i < NSLOT; i++) begin
         if (armed[i] && mode[i] == m) begin
            s = {1'b0, value[i]} + {1'b0, ms};
            value[i] = s[64] ? '1 : s[63:0];
         end
      end
   endtask

   task automatic arm_slot(input int s, input mode_type m);
      armed[s] = 1;
      mode[s] = m;
      value[s] = (m == MODE_IMM) ? ticks : 64'd0;
   endtask

   // Applies one accepted transaction to the predictor.
   task automatic predict_bank(input logic [1:0] k, input logic [31:0] d,
                               input logic [3:0] s, input logic [1:0] o);
      logic [63:0] ms, rdiv;
      read_result_type r;
      case (k)
         KIND_ADVANCE: begin
            ticks = ticks + {32'd0, d};
            if (!is_paused) begin
               credit_slots(MODE_REAL, base_ms(d, real_rem, real_div));
               credit_slots(MODE_GAME, base_ms(d, game_rem, game_div));
            end
         end
         KIND_START: begin
            if (o != MODE_BAD) arm_slot(s, mode_type'(o));
         end
         KIND_READ: begin
            ms = 0;
            r.found = 0;
            if (armed[s]) begin
               r.found = 1;
               rdiv = (real_div == 0) ? 64'd1 : {32'd0, real_div};
               ms = (mode[s] == MODE_IMM) ? (ticks - value[s]) / rdiv : value[s];
               if (o == RD_ERASE) armed[s] = 0;
               else if (o == RD_RESTART) arm_slot(s, mode[s]);
            end
            r.ms = (ms > {33'd0, MsMax}) ? MsMax : ms[30:0];
            pending_reads.push_back(r);
         end
         default: ;
      endcase
   endtask

   // Sends one transaction and predicts it once accepted.
   task automatic send_item(input logic [1:0] k, input logic [31:0] d,
                            input logic [3:0] s, input logic [1:0] o);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_kind <= k;
      req_delta_ticks <= d;
      req_slot <= s;
      req_option <= o;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_bank(k, d, s, o);
      @(negedge clock);
   endtask

   // Waits for all reads to return plus the longest advance time.
   task automatic drain_bank();
      req_valid <= 0;
      while (pending_reads.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_REAL:   real_div = data;
         CSR_GAME:   game_div = data;
         CSR_PAUSED: is_paused = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic random_item();
      int r;
      r = $urandom_range(99);
      if (r < 40)
         send_item(KIND_ADVANCE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(60000),
                   4'(0), 2'($urandom));
      else if (r < 65)
         send_item(KIND_START, $urandom, 4'($urandom), 2'($urandom_range(3)));
      else if (r < 97)
         send_item(KIND_READ, $urandom, 4'($urandom), 2'($urandom_range(3)));
      else
         send_item(KIND_NONE, $urandom, 4'($urandom), 2'($urandom));
   endtask

   // Directed: field extremes, every kind and option, special cases.
   task automatic test_directed();
      send_item(KIND_READ, 0, 4'd5, RD_KEEP);        // free slot read
      send_item(KIND_START, 0, 4'd0, MODE_REAL);
      send_item(KIND_START, 0, 4'd1, MODE_GAME);
      send_item(KIND_START, 0, 4'd2, MODE_IMM);
      send_item(KIND_START, 0, 4'd3, MODE_BAD);      // ignored
      send_item(KIND_ADVANCE, 32'hFFFF_FFFF, 4'hF, 2'd3);
      send_item(KIND_ADVANCE, 0, 4'd0, 2'd0);
      send_item(KIND_ADVANCE, 32'd12345, 4'd0, 2'd0);
      send_item(KIND_READ, 0, 4'd0, RD_KEEP);
      send_item(KIND_READ, 0, 4'd1, RD_RESTART);
      send_item(KIND_READ, 0, 4'd2, RD_KEEP2);
      send_item(KIND_READ, 0, 4'd3, RD_KEEP);
      send_item(KIND_NONE, 32'hFFFF_FFFF, 4'hF, 2'd3);
      send_item(KIND_READ, 0, 4'd0, RD_ERASE);
      send_item(KIND_READ, 0, 4'd0, RD_KEEP);        // erased slot
      send_item(KIND_START, 0, 4'hF, MODE_IMM);
      send_item(KIND_READ, 32'hFFFF_FFFF, 4'hF, RD_ERASE);
      drain_bank();
   endtask

   // Small and zero divisors, pause, and saturation of elapsed ms.
   task automatic test_divisors();
      write_csr(CSR_REAL, 0);
      write_csr(CSR_GAME, 1);
      send_item(KIND_START, 0, 4'd4, MODE_REAL);
      send_item(KIND_START, 0, 4'd5, MODE_GAME);
      send_item(KIND_START, 0, 4'd6, MODE_IMM);
      repeat (3) send_item(KIND_ADVANCE, 32'hFFFF_FFFF, 4'd0, 2'd0);
      send_item(KIND_READ, 0, 4'd4, RD_KEEP);
      send_item(KIND_READ, 0, 4'd5, RD_KEEP);
      send_item(KIND_READ, 0, 4'd6, RD_KEEP);
      drain_bank();
      write_csr(CSR_PAUSED, 1);
      send_item(KIND_ADVANCE, 32'd777, 4'd0, 2'd0);
      send_item(KIND_READ, 0, 4'd4, RD_KEEP);
      send_item(KIND_READ, 0, 4'd6, RD_KEEP);
      drain_bank();
      write_csr(CSR_PAUSED, 0);
      write_csr(CSR_REAL, 32'hFFFF_FFFF);
      write_csr(CSR_GAME, 32'hFFFF_FFFF);
      send_item(KIND_ADVANCE, 32'hFFFF_FFFF, 4'd0, 2'd0);
      send_item(KIND_ADVANCE, 32'd5, 4'd0, 2'd0);
      send_item(KIND_READ, 0, 4'd4, RD_RESTART);
      drain_bank();
   endtask

   // Random traffic over several settings and idle profiles.
   task automatic test_random();
      logic [31:0] rdivs [4] = '{32'd1, 32'd7, 32'd1000, 32'd10000};
      for (int ph = 0; ph < 6; ph++) begin
         send_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 45 : 0;
         recv_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 37 : 0;
         write_csr(CSR_REAL, rdivs[$urandom_range(3)]);
         write_csr(CSR_GAME, ($urandom_range(1) == 0) ? rdivs[$urandom_range(3)] : $urandom);
         write_csr(CSR_PAUSED, 32'(ph == 3));
         repeat (230) random_item();
         drain_bank();
      end
   endtask

   // Long receiver hold-off while reads keep coming.
   task automatic test_backpressure();
      hold_req++;
      for (int i = 0; i < 8; i++) begin
         send_item(KIND_START, 0, 4'(i), MODE_IMM);
         send_item(KIND_READ, 0, 4'(i), RD_KEEP);
      end
      drain_bank();
   endtask

   // Receiver stall control; a hold request holds rsp_stall high until the hold counter runs out
   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1;
      end else if (hold_done != hold_req) begin
         hold_done <= hold_req;
         hold_cycles <= 399;
         rsp_stall <= 1;
      end else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Result checker
   int mismatches_shown = 0;
   always @(posedge clock) begin
      read_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reads.size() == 0) begin
            errors++;
            if (mismatches_shown++ < 10) $display("unexpected result ms=%0d found=%0b",
                                                  rsp_elapsed_ms, rsp_found);
         end else begin
            want = pending_reads.pop_front();
            if (want.ms !== rsp_elapsed_ms || want.found !== rsp_found) begin
               errors++;
               if (mismatches_shown++ < 10)
                  $display("mismatch: expected ms=%0d found=%0b, got ms=%0d found=%0b",
                           want.ms, want.found, rsp_elapsed_ms, rsp_found);
            end
         end
      end
   end

   initial begin
      req_valid = 0;
      req_kind = 0;
      req_delta_ticks = 0;
      req_slot = 0;
      req_option = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_wdata = 0;
      real_div = TicksPerMsReset;
      game_div = TicksPerMsReset;
      is_paused = 0;
      ticks = 0;
      real_rem = 0;
      game_rem = 0;
      for (int i = 0; i < NSLOT; i++) begin
         armed[i] = 0;
         mode[i] = MODE_REAL;
         value[i] = 0;
      end
      reset = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_divisors();
      test_backpressure();
      test_random();
      if (errors == 0 && pending_reads.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #200ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
